/* rtl/nplf_pkg.sv */
// shared types and constants for the noise palette frame core
`timescale 1ns / 1ps
package nplf_pkg;

  localparam logic [31:0] HashMulT  = 32'd131;
  localparam logic [31:0] HashMulA  = 32'd15731;
  localparam logic [31:0] HashAddB  = 32'd789221;
  localparam logic [31:0] HashAddC  = 32'd1376312589;
  localparam logic [15:0] PixStep   = 16'd50;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_H_SQ,
    ST_H_POLY,
    ST_H_MUL,
    ST_H_WR,
    ST_S_RD,
    ST_S_WR,
    ST_C_RDA,
    ST_C_RDB,
    ST_C_MIX,
    ST_C_R,
    ST_C_G,
    ST_C_B,
    ST_C_OUT
  } state_e;

  // one channel of a palette entry
  function automatic logic [7:0] pal_chan(input logic [3:0] idx, input logic [1:0] ch);
    logic [23:0] c;
    case (idx)
      4'd0:  c = 24'h5500AB;
      4'd1:  c = 24'h84007C;
      4'd2:  c = 24'hB5004B;
      4'd3:  c = 24'hE5001A;
      4'd4:  c = 24'hE81700;
      4'd5:  c = 24'hB84700;
      4'd6:  c = 24'hAB7700;
      4'd7:  c = 24'hABAB00;
      4'd8:  c = 24'hAB5500;
      4'd9:  c = 24'hDD2200;
      4'd10: c = 24'hF2000E;
      4'd11: c = 24'hC2003D;
      4'd12: c = 24'h8F0070;
      4'd13: c = 24'h5F00A0;
      4'd14: c = 24'h2F00D0;
      default: c = 24'h0007F6;
    endcase
    case (ch)
      2'd0:    pal_chan = c[23:16];
      2'd1:    pal_chan = c[15:8];
      default: pal_chan = c[7:0];
    endcase
  endfunction

endpackage

/* rtl/nplf_if.sv */
// valid/ready channel interfaces for requests, pixels and configuration
`timescale 1ns / 1ps
interface nplf_req_if;
  logic        valid;
  logic        ready;
  logic [31:0] time_ms;
  modport source (output valid, output time_ms, input ready);
  modport sink   (input valid, input time_ms, output ready);
endinterface

interface nplf_pix_if;
  logic       valid;
  logic       ready;
  logic [5:0] pixel_index;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       last_pixel;
  modport source (output valid, output pixel_index, output red, output green,
                  output blue, output last_pixel, input ready);
  modport sink   (input valid, input pixel_index, input red, input green,
                  input blue, input last_pixel, output ready);
endinterface

interface nplf_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/noise_palette_led_frame_core.sv */
// frame core: hash noise row, two smoothing passes, palette colour output
`timescale 1ns / 1ps
// Usage: a request transfer on req carries time_ms; the core then emits one
// pixel transfer per active pixel on pix, pixel_index ascending, last_pixel
// set on the final one. Active length is the strip_length register (cfg
// channel, reset 64) clipped to MAX_PIXELS; a length of zero emits nothing.
// req is ready only while the core is idle, one frame at a time.
// One shared 32x32 multiplier serves hashing (three products a pixel) and
// brightness scaling (three products a pixel); the noise row lives in a
// single-port memory with registered read; a frame runs hashing, then two
// smoothing passes (none for N=1), then colour output, pixel by pixel for
// N active pixels, with output stalls holding the colour phase.
// A stalled receiver holds the pixel register; the sequencer waits on it.
// Reset returns the sequencer to idle; the row needs no clearing.
module noise_palette_led_frame_core #(
  parameter int MAX_PIXELS = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  nplf_req_if.sink   req,
  nplf_pix_if.source pix,
  nplf_cfg_if.sink   cfg
);
  import nplf_pkg::*;

  localparam int AW = $clog2(MAX_PIXELS);
  localparam int LW = AW + 1;

  state_e      state_q, state_d;
  logic [6:0]  len_reg_q;
  logic [LW-1:0] len_q, len_d;
  logic [AW-1:0] idx_q, idx_d;
  logic        pass_q, pass_d;
  logic [31:0] n_q, n_d, acc_q, acc_d, t_q, t_d;
  logic [7:0]  prev_q, prev_d, val_q, val_d, bri_q, bri_d;
  logic [7:0]  r_q, r_d, g_q, g_d, b_q, b_d;
  logic        ov_q, ov_d;
  logic [5:0]  oi_q;
  logic [7:0]  or_q, og_q, ob_q;
  logic        ol_q, load_out;

  // noise row memory
  logic [7:0]    row_mem [MAX_PIXELS];
  logic [7:0]    rd_q;
  logic [AW-1:0] addr;
  logic          we;
  logic [7:0]    wd;
  always_ff @(posedge clk_i) begin
    if (we) row_mem[addr] <= wd;
    rd_q <= row_mem[addr];
  end

  // shared multiplier
  logic [31:0] ma, mb, mp;
  assign mp = ma * mb;

  logic [LW-1:0] len_clip;
  assign len_clip = (int'(len_reg_q) > MAX_PIXELS) ? LW'(MAX_PIXELS)
                                                   : LW'(len_reg_q);
  logic [AW-1:0] last_idx;
  assign last_idx = AW'(len_q - 1'b1);
  logic [3:0]  hi, hn, fr;
  assign hi = val_q[7:4];
  assign hn = hi + 4'd1;
  assign fr = val_q[3:0];
  logic [31:0] hx;
  assign hx = 32'(16'(idx_q) * PixStep) + t_q;
  // brightness divide by 255: v*255+... exact via (p + 1 + (p>>8)) >> 8
  logic [15:0] p16;
  logic [7:0]  q255;
  assign p16  = mp[15:0];
  assign q255 = 8'((17'(p16) + 17'd1 + 17'(p16[15:8])) >> 8);
  function automatic logic [7:0] mix(input logic [7:0] a, input logic [7:0] b,
                                     input logic [3:0] f);
    logic [12:0] s;
    s = 13'(a) * (13'd16 - 13'(f)) + 13'(b) * 13'(f);
    mix = s[11:4];
  endfunction

  assign req.ready = (state_q == ST_IDLE);
  assign cfg.ready = 1'b1;
  assign pix.valid = ov_q;
  assign pix.pixel_index = oi_q;
  assign pix.red = or_q;
  assign pix.green = og_q;
  assign pix.blue = ob_q;
  assign pix.last_pixel = ol_q;

  // sequencer
  always_comb begin
    state_d = state_q; len_d = len_q; idx_d = idx_q; pass_d = pass_q;
    n_d = n_q; acc_d = acc_q; t_d = t_q; prev_d = prev_q; val_d = val_q;
    bri_d = bri_q; r_d = r_q; g_d = g_q; b_d = b_q;
    ov_d = ov_q && !pix.ready; load_out = 1'b0;
    ma = n_q; mb = n_q; addr = idx_q; we = 1'b0; wd = 8'd0;
    case (state_q)
      ST_IDLE: begin
        if (req.valid && len_clip != '0) begin
          len_d = len_clip; idx_d = '0; pass_d = 1'b0;
          t_d = 32'(req.time_ms[31:5]) * HashMulT;
          state_d = ST_H_SQ;
        end
      end
      ST_H_SQ: begin
        n_d = (hx[18:0] << 13) ^ hx;
        state_d = ST_H_POLY;
      end
      ST_H_POLY: begin
        acc_d = mp; state_d = ST_H_MUL;
      end
      ST_H_MUL: begin
        ma = acc_q; mb = HashMulA;
        acc_d = mp + HashAddB; state_d = ST_H_WR;
      end
      ST_H_WR: begin
        ma = n_q; mb = acc_q;
        we = 1'b1; wd = 8'((mp + HashAddC) >> 24);
        if (idx_q == last_idx) begin
          idx_d = '0;
          state_d = (len_q == LW'(1)) ? ST_C_RDA : ST_S_RD;
        end else begin
          idx_d = idx_q + 1'b1; state_d = ST_H_SQ;
        end
      end
      ST_S_RD: state_d = ST_S_WR;
      ST_S_WR: begin
        if (idx_q != '0) begin
          addr = idx_q - 1'b1; we = 1'b1;
          wd = 8'((9'(prev_q) + 9'(rd_q)) >> 1);
        end
        prev_d = rd_q;
        if (idx_q == last_idx) begin
          idx_d = '0; pass_d = 1'b1;
          state_d = pass_q ? ST_C_RDA : ST_S_RD;
        end else begin
          idx_d = idx_q + 1'b1; state_d = ST_S_RD;
        end
      end
      ST_C_RDA: begin
        state_d = ST_C_RDB;
      end
      ST_C_RDB: begin
        addr = last_idx - idx_q; val_d = rd_q; state_d = ST_C_MIX;
      end
      ST_C_MIX: begin
        bri_d = rd_q;
        r_d = mix(pal_chan(hi, 2'd0), pal_chan(hn, 2'd0), fr);
        g_d = mix(pal_chan(hi, 2'd1), pal_chan(hn, 2'd1), fr);
        b_d = mix(pal_chan(hi, 2'd2), pal_chan(hn, 2'd2), fr);
        state_d = ST_C_R;
      end
      ST_C_R: begin
        ma = 32'(r_q); mb = 32'(bri_q); r_d = q255; state_d = ST_C_G;
      end
      ST_C_G: begin
        ma = 32'(g_q); mb = 32'(bri_q); g_d = q255; state_d = ST_C_B;
      end
      ST_C_B: begin
        ma = 32'(b_q); mb = 32'(bri_q); b_d = q255; state_d = ST_C_OUT;
      end
      ST_C_OUT: begin
        if (!ov_q || pix.ready) begin
          ov_d = 1'b1; load_out = 1'b1;
          if (idx_q == last_idx) begin
            idx_d = '0; state_d = ST_IDLE;
          end else begin
            idx_d = idx_q + 1'b1; state_d = ST_C_RDA;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; len_reg_q <= 7'd64; ov_q <= 1'b0;
      len_q <= '0; idx_q <= '0; pass_q <= 1'b0;
    end else begin
      state_q <= state_d; ov_q <= ov_d;
      len_q <= len_d; idx_q <= idx_d; pass_q <= pass_d;
      if (cfg.valid) len_reg_q <= cfg.data;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    n_q <= n_d; acc_q <= acc_d; t_q <= t_d; prev_q <= prev_d; val_q <= val_d;
    bri_q <= bri_d; r_q <= r_d; g_q <= g_d; b_q <= b_d;
    if (load_out) begin
      oi_q <= 6'(idx_q); or_q <= r_q; og_q <= g_q; ob_q <= b_q;
      ol_q <= (idx_q == last_idx);
    end
  end

  // checks
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.ready |-> (state_q == ST_IDLE)) else $error("ready outside idle");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix.valid && !pix.ready) |=> (pix.valid && $stable(pix.pixel_index)))
    else $error("pixel dropped under stall");
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> (LW'(idx_q) < len_q)) else $error("index overrun");
endmodule

/* test/noise_palette_led_frame_core_tb.sv */
// testbench for the noise palette frame core: self-predicting, randomised, back-pressured
`timescale 1ns / 1ps
module noise_palette_led_frame_core_tb;

  localparam int MaxPixels = 64;
  localparam int QuietCycles = 200;

  localparam logic [23:0] Colours [16] = '{
    24'h5500AB, 24'h84007C, 24'hB5004B, 24'hE5001A,
    24'hE81700, 24'hB84700, 24'hAB7700, 24'hABAB00,
    24'hAB5500, 24'hDD2200, 24'hF2000E, 24'hC2003D,
    24'h8F0070, 24'h5F00A0, 24'h2F00D0, 24'h0007F6
  };

  typedef struct packed {
    logic [5:0] index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } pixel_t;

  logic clk_i;
  logic rst_ni;

  nplf_req_if req_ch ();
  nplf_pix_if pix_ch ();
  nplf_cfg_if cfg_ch ();

  noise_palette_led_frame_core #(.MAX_PIXELS(MaxPixels)) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req   (req_ch),
    .pix   (pix_ch),
    .cfg   (cfg_ch)
  );

  pixel_t     pixels_due[$];
  logic [6:0] strip_len;
  int         errors;
  int         frames_sent;
  bit         idle_on;
  int         hold_left;
  int         stall_left;

  // clock and reset
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // watchdog
  initial begin
    #50ms;
    $display("CHECKS FAILED");
    $finish;
  end

  // one colour channel, blended then scaled by brightness
  function automatic logic [7:0] blend_scale(input logic [7:0] a, input logic [7:0] b,
                                             input logic [3:0] frac, input logic [7:0] br);
    int unsigned v;
    v = (a * (16 - frac) + b * frac) >> 4;
    v = (v * br) / 255;
    return v[7:0];
  endfunction

  // work out the pixels of one frame and queue them
  function automatic void predict_frame(input logic [31:0] time_ms);
    logic [7:0]  row [MaxPixels];
    logic [31:0] t;
    logic [31:0] n;
    logic [7:0]  prev;
    logic [7:0]  cur;
    logic [7:0]  lvl;
    logic [7:0]  br;
    logic [23:0] c1;
    logic [23:0] c2;
    int          len;
    pixel_t      p;
    len = (strip_len > MaxPixels) ? MaxPixels : strip_len;
    if (len == 0) return;
    t = time_ms >> 5;
    // integer hash per pixel
    for (int i = 0; i < len; i++) begin
      n = (32'(i * 50) & 32'hFFFF) + t * 32'd131;
      n = (n << 13) ^ n;
      n = n * (n * n * 32'd15731 + 32'd789221) + 32'd1376312589;
      row[i] = n[31:24];
    end
    // two in-place neighbour averaging passes
    for (int pass = 0; pass < 2; pass++) begin
      prev = row[0];
      for (int i = 1; i < len; i++) begin
        cur = row[i];
        row[i - 1] = 8'((9'(prev) + 9'(cur)) >> 1);
        prev = cur;
      end
    end
    // palette lookup with mirrored brightness
    for (int i = 0; i < len; i++) begin
      lvl = row[i];
      br = row[len - 1 - i];
      c1 = Colours[lvl[7:4]];
      c2 = Colours[4'(lvl[7:4] + 4'd1)];
      p.index = 6'(i);
      p.red   = blend_scale(c1[23:16], c2[23:16], lvl[3:0], br);
      p.green = blend_scale(c1[15:8], c2[15:8], lvl[3:0], br);
      p.blue  = blend_scale(c1[7:0], c2[7:0], lvl[3:0], br);
      p.last  = (i == len - 1);
      pixels_due.push_back(p);
    end
  endfunction

  task automatic report(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // pixel receiver: random stall bursts, plus long hold-off on request
  initial begin
    pix_ch.ready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        pix_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        pix_ch.ready <= 1'b0;
      end else if (idle_on && rst_ni && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 17);
        pix_ch.ready <= 1'b0;
      end else begin
        pix_ch.ready <= rst_ni;
      end
    end
  end

  // compare each pixel transfer against the oldest expectation
  always @(posedge clk_i) begin
    pixel_t want;
    if (rst_ni && pix_ch.valid && pix_ch.ready) begin
      if (pixels_due.size() == 0) begin
        report("unexpected pixel", pix_ch.pixel_index, -1);
      end else begin
        want = pixels_due.pop_front();
        if (pix_ch.pixel_index !== want.index) report("pixel_index", pix_ch.pixel_index, want.index);
        if (pix_ch.red !== want.red)           report("red", pix_ch.red, want.red);
        if (pix_ch.green !== want.green)       report("green", pix_ch.green, want.green);
        if (pix_ch.blue !== want.blue)         report("blue", pix_ch.blue, want.blue);
        if (pix_ch.last_pixel !== want.last)   report("last_pixel", pix_ch.last_pixel, want.last);
      end
    end
  end

  // one frame request transfer, with an optional idle burst first
  task automatic send_frame(input logic [31:0] time_ms);
    @(negedge clk_i);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 18)) @(negedge clk_i);
    end
    req_ch.valid   <= 1'b1;
    req_ch.time_ms <= time_ms;
    forever begin
      @(posedge clk_i);
      if (req_ch.ready) break;
    end
    predict_frame(time_ms);
    frames_sent++;
    @(negedge clk_i);
    req_ch.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pixels_due.size() != 0) @(posedge clk_i);
    repeat (QuietCycles) @(posedge clk_i);
  endtask

  // strip length write, only with the core idle
  task automatic set_length(input logic [6:0] len);
    wait_drained();
    @(negedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= len;
    forever begin
      @(posedge clk_i);
      if (cfg_ch.ready) break;
    end
    strip_len = len;
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic test_directed();
    // reset length, time extremes and shift boundary
    send_frame(32'h0000_0000);
    send_frame(32'hFFFF_FFFF);
    send_frame(32'h0000_001F);
    send_frame(32'h0000_0020);
    send_frame(32'h8000_0000);
    // single pixel is its own mirror
    set_length(7'd1);
    send_frame(32'h1234_5678);
    send_frame(32'hFFFF_FFFF);
    // zero length emits nothing
    set_length(7'd0);
    send_frame(32'hDEAD_BEEF);
    send_frame(32'h0000_0000);
    // long strips clipped to the maximum, then lengths of 2, 63 and 64
    set_length(7'd127);
    send_frame(32'h5555_5555);
    set_length(7'd65);
    send_frame(32'hAAAA_AAAA);
    set_length(7'd2);
    send_frame(32'h0000_0040);
    send_frame(32'h7FFF_FFE0);
    set_length(7'd63);
    send_frame(32'hC0FF_EE00);
    set_length(7'd64);
    send_frame(32'h0F0F_0F0F);
  endtask

  function automatic logic [6:0] pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 7'd64;
    if (r < 15) return 7'($urandom_range(65, 127));
    if (r < 20) return 7'd0;
    if (r < 25) return 7'd1;
    return 7'($urandom_range(2, 20));
  endfunction

  task automatic test_random(input int target);
    int done;
    int burst;
    done = 0;
    while (done < target) begin
      set_length(pick_length());
      burst = $urandom_range(5, 15);
      for (int k = 0; k < burst; k++) begin
        send_frame($urandom());
        if (strip_len != 0) done++;
      end
    end
  endtask

  // receiver holds off while requests keep coming, so the core stalls
  task automatic test_backpressure();
    set_length(7'd64);
    hold_left = 600;
    for (int k = 0; k < 3; k++) send_frame($urandom());
  endtask

  task automatic test_no_idle();
    wait_drained();
    idle_on = 1'b0;
    set_length(7'd16);
    for (int k = 0; k < 10; k++) send_frame($urandom());
    set_length(7'd64);
    for (int k = 0; k < 4; k++) send_frame($urandom());
  endtask

  // sequence of tests
  initial begin
    req_ch.valid   = 1'b0;
    req_ch.time_ms = '0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.data    = '0;
    strip_len   = 7'd64;
    errors      = 0;
    frames_sent = 0;
    hold_left   = 0;
    idle_on     = 1'b1;
    @(posedge rst_ni);
    repeat (2) @(posedge clk_i);
    test_directed();
    test_backpressure();
    test_random(310);
    test_no_idle();
    wait_drained();
    if (pixels_due.size() != 0) report("pixels left over", pixels_due.size(), 0);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/nplf_pkg.sv
rtl/nplf_if.sv
rtl/noise_palette_led_frame_core.sv
test/noise_palette_led_frame_core_tb.sv
